// File: rtl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

  // field widths
  localparam int DUTY_FIELD_W  = 12;
  localparam int PERIOD_W      = 16;
  localparam int STEPS_W       = 16;
  localparam int TICK_W        = 22;
  localparam int CFG_DATA_W    = 22;
  localparam int CFG_INDEX_W   = 3;
  localparam int STEP_W        = 3;
  localparam int PHASES        = 3;

  // register defaults
  localparam int DUTY_BITS_DEFAULT = 12;
  localparam logic [DUTY_FIELD_W-1:0] RESET_DUTY      = 12'd2000;
  localparam logic [PERIOD_W-1:0]     RESET_PERIOD    = 16'd3645;
  localparam logic [STEPS_W-1:0]      RESET_STEPS     = 16'd3600;
  localparam logic [TICK_W-1:0]       RESET_PRECHARGE = 22'd2000000;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRECHARGE = 3'd3;

  localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

  typedef enum logic [1:0] {
    MODE_PRE   = 2'd0,
    MODE_START = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DUTY_FIELD_W-1:0] duty;
    logic [PERIOD_W-1:0]     startup_period;
    logic [STEPS_W-1:0]      startup_steps;
    logic [TICK_W-1:0]       precharge_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_FIELD_W-1:0] duty_a;
    logic [DUTY_FIELD_W-1:0] duty_b;
    logic [DUTY_FIELD_W-1:0] duty_c;
    logic [PHASES-1:0]       low_side_n;
    logic [STEP_W-1:0]       step_index;
    mode_t                   mode;
  } drive_t;

  // phase driven high in each step
  function automatic logic [1:0] hi_phase(input logic [STEP_W-1:0] s);
    logic [1:0] p;
    case (s)
      3'd0, 3'd1: p = 2'd0;
      3'd2, 3'd3: p = 2'd1;
      3'd4, 3'd5: p = 2'd2;
      default:    p = 2'd0;
    endcase
    return p;
  endfunction

  // phase pulled low in each step
  function automatic logic [1:0] lo_phase(input logic [STEP_W-1:0] s);
    logic [1:0] p;
    case (s)
      3'd0:       p = 2'd1;
      3'd1, 3'd2: p = 2'd2;
      3'd3, 3'd4: p = 2'd0;
      3'd5:       p = 2'd1;
      default:    p = 2'd1;
    endcase
    return p;
  endfunction

  // floating phase watched for the back-emf crossing
  function automatic logic [1:0] sense_phase(input logic [STEP_W-1:0] s);
    logic [1:0] p;
    case (s)
      3'd0, 3'd3: p = 2'd2;
      3'd1, 3'd4: p = 2'd1;
      3'd2, 3'd5: p = 2'd0;
      default:    p = 2'd2;
    endcase
    return p;
  endfunction

  function automatic logic edge_seen(input logic [STEP_W-1:0] s,
                                     input logic [PHASES-1:0] was,
                                     input logic [PHASES-1:0] now);
    logic b_was;
    logic b_now;
    b_was = was[sense_phase(s)];
    b_now = now[sense_phase(s)];
    // even steps expect a rising edge, odd steps a falling one
    if (s[0] == 1'b0) begin
      return !b_was && b_now;
    end
    return b_was && !b_now;
  endfunction

  function automatic logic [STEP_W-1:0] advance(input logic [STEP_W-1:0] s);
    return (s >= LAST_STEP) ? '0 : s + 3'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bldc_six_step_commutator.sv
// channel   | handshake                | payload
// ----------+--------------------------+----------------------------------------------
// input     | in_valid / in_stall      | sensor_levels
// output    | out_valid / out_stall    | duty_a, duty_b, duty_c, low_side_n,
//           |                          | step_index, mode
// config    | cfg_write (no wait)      | cfg_index, cfg_data
//
// one tick per cycle while the output is not stalled; a tick waits in the input register, and its
// drive pattern is written into the output register when the tick leaves the input register
// out_valid rises once an accepted tick moves from the input register into the output register
// rst is synchronous: precharge state, all counters cleared, registers at defaults
// a stalled output freezes the pipe; one more tick can wait in the input register
`default_nettype none

module bldc_six_step_commutator #(
  parameter int DUTY_BITS = bsc_pkg::DUTY_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // tick channel
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [bsc_pkg::PHASES-1:0]          sensor_levels,
  // drive channel
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [bsc_pkg::DUTY_FIELD_W-1:0]    duty_a,
  output      logic [bsc_pkg::DUTY_FIELD_W-1:0]    duty_b,
  output      logic [bsc_pkg::DUTY_FIELD_W-1:0]    duty_c,
  output      logic [bsc_pkg::PHASES-1:0]          low_side_n,
  output      logic [bsc_pkg::STEP_W-1:0]          step_index,
  output      logic [1:0]                          mode,
  // register writes
  input  wire logic                                cfg_write,
  input  wire logic [bsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bsc_pkg::cfg_t   cfg;
  bsc_pkg::drive_t drive;
  bsc_pkg::drive_t result;

  // input register
  logic                        hold_valid;
  logic [bsc_pkg::PHASES-1:0]  hold_levels;

  logic move;    // output register can take a new pattern this cycle
  logic accept;  // input transaction
  logic fire;    // tick leaves the input register and updates the state

  assign move     = !out_valid || !out_stall;
  assign in_stall = hold_valid && !move;
  assign accept   = in_valid && !in_stall;
  assign fire     = hold_valid && move;

  bsc_cfg_regs #(
    .DUTY_BITS (DUTY_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // counters, step table and edge detect; state moves only when a tick fires
  bsc_commutate u_comm (
    .clk    (clk),
    .rst    (rst),
    .tick   (fire),
    .levels (hold_levels),
    .cfg    (cfg),
    .drive  (drive)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_levels <= sensor_levels;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= hold_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      result <= drive;
    end
  end

  assign duty_a     = result.duty_a;
  assign duty_b     = result.duty_b;
  assign duty_c     = result.duty_c;
  assign low_side_n = result.low_side_n;
  assign step_index = result.step_index;
  assign mode       = result.mode;

endmodule

`default_nettype wire

// File: rtl/bsc_cfg_regs.sv
`default_nettype none

module bsc_cfg_regs #(
  parameter int DUTY_BITS = bsc_pkg::DUTY_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [bsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bsc_pkg::cfg_t                         cfg
);

  // duty storage keeps only the bits that survive both masks
  localparam int DUTY_W = (DUTY_BITS < bsc_pkg::DUTY_FIELD_W) ? DUTY_BITS
                                                              : bsc_pkg::DUTY_FIELD_W;

  logic [DUTY_W-1:0]               duty;
  logic [bsc_pkg::PERIOD_W-1:0]    startup_period;
  logic [bsc_pkg::STEPS_W-1:0]     startup_steps;
  logic [bsc_pkg::TICK_W-1:0]      precharge_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty            <= bsc_pkg::RESET_DUTY[DUTY_W-1:0];
      startup_period  <= bsc_pkg::RESET_PERIOD;
      startup_steps   <= bsc_pkg::RESET_STEPS;
      precharge_ticks <= bsc_pkg::RESET_PRECHARGE;
    end else if (cfg_write) begin
      case (cfg_index)
        bsc_pkg::REG_DUTY:      duty            <= cfg_data[DUTY_W-1:0];
        bsc_pkg::REG_PERIOD:    startup_period  <= cfg_data[bsc_pkg::PERIOD_W-1:0];
        bsc_pkg::REG_STEPS:     startup_steps   <= cfg_data[bsc_pkg::STEPS_W-1:0];
        bsc_pkg::REG_PRECHARGE: precharge_ticks <= cfg_data[bsc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.duty            = bsc_pkg::DUTY_FIELD_W'(duty);
    cfg.startup_period  = startup_period;
    cfg.startup_steps   = startup_steps;
    cfg.precharge_ticks = precharge_ticks;
  end

endmodule

`default_nettype wire

// File: rtl/bsc_commutate.sv
`default_nettype none

module bsc_commutate (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         tick,
  input  wire logic [bsc_pkg::PHASES-1:0]   levels,
  input  wire bsc_pkg::cfg_t                cfg,
  output bsc_pkg::drive_t                   drive
);

  logic [bsc_pkg::STEP_W-1:0]   step;
  bsc_pkg::mode_t               phase_mode;
  logic [bsc_pkg::TICK_W-1:0]   tick_count;
  logic [bsc_pkg::STEPS_W-1:0]  forced_count;
  logic [bsc_pkg::PHASES-1:0]   last_levels;
  logic                         outputs_live;

  logic [bsc_pkg::STEP_W-1:0]   step_next;
  bsc_pkg::mode_t               phase_mode_next;
  logic [bsc_pkg::TICK_W-1:0]   tick_count_next;
  logic [bsc_pkg::STEPS_W-1:0]  forced_count_next;
  logic                         outputs_live_next;

  logic [bsc_pkg::PERIOD_W-1:0] per;
  logic [bsc_pkg::STEPS_W-1:0]  nsteps;
  logic [bsc_pkg::TICK_W-1:0]   tick_inc;
  logic [bsc_pkg::STEPS_W:0]    forced_plus1;
  logic [bsc_pkg::STEPS_W-1:0]  forced_inc;
  logic                         edge_hit;
  logic                         start_now;

  assign per          = (cfg.startup_period == '0) ? bsc_pkg::PERIOD_W'(1) : cfg.startup_period;
  assign nsteps       = (cfg.startup_steps == '0) ? bsc_pkg::STEPS_W'(1) : cfg.startup_steps;
  assign start_now    = (phase_mode == bsc_pkg::MODE_PRE) && (tick_count >= cfg.precharge_ticks);
  assign tick_inc     = (start_now ? '0 : tick_count) + bsc_pkg::TICK_W'(1);
  assign forced_plus1 = {1'b0, forced_count} + (bsc_pkg::STEPS_W + 1)'(1);
  assign forced_inc   = forced_count + bsc_pkg::STEPS_W'(1);
  assign edge_hit     = outputs_live && bsc_pkg::edge_seen(step, last_levels, levels);

  // next state
  always_comb begin
    step_next         = step;
    phase_mode_next   = phase_mode;
    tick_count_next   = tick_count;
    forced_count_next = forced_count;
    outputs_live_next = outputs_live;
    if (phase_mode == bsc_pkg::MODE_PRE && !start_now) begin
      tick_count_next = tick_inc;
    end else if (phase_mode == bsc_pkg::MODE_PRE || phase_mode == bsc_pkg::MODE_START) begin
      phase_mode_next = bsc_pkg::MODE_START;
      // edges count only in the last forced step window
      if (edge_hit && forced_plus1 >= {1'b0, nsteps}) begin
        step_next = bsc_pkg::advance(step);
      end
      tick_count_next = tick_inc;
      if (tick_inc >= bsc_pkg::TICK_W'(per)) begin
        tick_count_next   = '0;
        step_next         = bsc_pkg::advance(step_next);
        outputs_live_next = 1'b1;
        forced_count_next = forced_inc;
        if (forced_inc >= nsteps) begin
          phase_mode_next = bsc_pkg::MODE_RUN;
        end
      end
    end else begin
      phase_mode_next = bsc_pkg::MODE_RUN;
      if (edge_hit) begin
        step_next = bsc_pkg::advance(step);
      end
    end
  end

  // drive pattern from the updated state
  always_comb begin
    drive.duty_a     = '0;
    drive.duty_b     = '0;
    drive.duty_c     = '0;
    drive.step_index = step_next;
    drive.mode       = phase_mode_next;
    if (phase_mode_next == bsc_pkg::MODE_PRE) begin
      drive.low_side_n = '0;
    end else if (!outputs_live_next) begin
      drive.low_side_n = '1;
    end else begin
      case (bsc_pkg::hi_phase(step_next))
        2'd0:    drive.duty_a = cfg.duty;
        2'd1:    drive.duty_b = cfg.duty;
        2'd2:    drive.duty_c = cfg.duty;
        default: ;
      endcase
      drive.low_side_n = ~(bsc_pkg::PHASES'(1) << bsc_pkg::lo_phase(step_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      phase_mode   <= bsc_pkg::MODE_PRE;
      tick_count   <= '0;
      forced_count <= '0;
      last_levels  <= '0;
      outputs_live <= 1'b0;
    end else if (tick) begin
      step         <= step_next;
      phase_mode   <= phase_mode_next;
      tick_count   <= tick_count_next;
      forced_count <= forced_count_next;
      last_levels  <= levels;
      outputs_live <= outputs_live_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= bsc_pkg::LAST_STEP)
    else $error("commutation step out of range");

  a_pre_dark: assert property (@(posedge clk) disable iff (rst)
    (phase_mode == bsc_pkg::MODE_PRE) |-> !outputs_live)
    else $error("high sides live during precharge");

  a_run_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase_mode == bsc_pkg::MODE_RUN) |=> (phase_mode == bsc_pkg::MODE_RUN))
    else $error("left closed-loop run");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(step) && $stable(tick_count))
    else $error("state moved without a tick");

endmodule

`default_nettype wire
